// File: hdl/sdp_pkg.sv
package sdp_pkg;

	// Widths of counters
	localparam int STEP_COUNT_BITS = 16;
	localparam int TIMER_BITS      = 20;
	localparam int CFG_W           = 20;
	localparam int CFG_IDX_W       = 2;
	localparam int POS_W           = 32;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAKE_TIME   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STAB_TIME   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_DIR  = 2'd3;

	// Register reset values
	localparam logic [CFG_W-1:0] HALF_PERIOD_RST = CFG_W'(1000);
	localparam logic [CFG_W-1:0] WAKE_TIME_RST   = CFG_W'(100 * 1000);
	localparam logic [CFG_W-1:0] STAB_TIME_RST   = CFG_W'(200 * 1000);

	// Command codes
	localparam logic [2:0] FUNC_TICK = 3'd0;
	localparam logic [2:0] FUNC_MOVE = 3'd1;
	localparam logic [2:0] FUNC_HOME = 3'd2;
	localparam logic [2:0] FUNC_OFF  = 3'd3;
	localparam logic [2:0] FUNC_HOLD = 3'd4;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_MOVE_WAKE = 3'd1,
		MODE_MOVE_HIGH = 3'd2,
		MODE_MOVE_LOW  = 3'd3,
		MODE_HOME_WAKE = 3'd4,
		MODE_HOME_HIGH = 3'd5,
		MODE_HOME_LOW  = 3'd6,
		MODE_STABILIZE = 3'd7
	} mode_t;

	typedef struct packed {
		logic [CFG_W-1:0] half_period;
		logic [CFG_W-1:0] wake_time;
		logic [CFG_W-1:0] stab_time;
		logic             origin_dir;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  func;
		logic        move_direction;
		logic [15:0] step_count;
		logic        origin_switch;
	} cmd_t;

	typedef struct packed {
		logic              step_pulse;
		logic              direction_line;
		logic              driver_enable;
		logic [POS_W-1:0]  position;
		logic              busy_res;
	} res_t;

	// Clamp a register value to the timer range
	function automatic logic [TIMER_BITS-1:0] sat_timer(input logic [CFG_W-1:0] v);
		logic [CFG_W+TIMER_BITS-1:0] vw;
		vw = (CFG_W + TIMER_BITS)'(v);
		if (vw > (CFG_W + TIMER_BITS)'(TIMER_MAX))
			return TIMER_MAX;
		return TIMER_BITS'(v);
	endfunction

	// Half-period in ticks, never zero
	function automatic logic [TIMER_BITS-1:0] half_ticks(input logic [CFG_W-1:0] v);
		logic [TIMER_BITS-1:0] h;
		h = sat_timer(v);
		return (h == '0) ? TIMER_BITS'(1) : h;
	endfunction

endpackage

// File: hdl/sdp_if.sv
// Command channel
interface sdp_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic        move_direction;
	logic [15:0] step_count;
	logic        origin_switch;

	modport source (output valid, func, move_direction, step_count, origin_switch,
		input ready);
	modport sink (input valid, func, move_direction, step_count, origin_switch,
		output ready);
endinterface

// Result channel
interface sdp_res_if;
	logic               valid;
	logic               ready;
	logic               step_pulse;
	logic               direction_line;
	logic               driver_enable;
	logic signed [31:0] position;
	logic               busy_res;

	modport source (output valid, step_pulse, direction_line, driver_enable, position,
		busy_res, input ready);
	modport sink (input valid, step_pulse, direction_line, driver_enable, position,
		busy_res, output ready);
endinterface

// File: hdl/stepper_step_dir_pulse_controller_core.sv
// Step/dir pulse controller.
// Each result is registered in the output buffer before it is presented.
// Throughput: one request per cycle while the output buffer can take a result.
// A two-entry output buffer keeps requests flowing while one result waits.
// Reset (arst_n low, asynchronous): idle, lines low, position 0, registers
// at 1000, 100000, 200000 and 0; no clearing pass.
module stepper_step_dir_pulse_controller_core
	import sdp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sdp_cmd_if.sink              cmd,
	sdp_res_if.source            res
);

	cfg_t cfg;
	cmd_t cmd_in;
	res_t res_d;
	res_t res_out;
	logic acc;

	assign acc = cmd.valid && cmd.ready;

	assign cmd_in.func           = cmd.func;
	assign cmd_in.move_direction = cmd.move_direction;
	assign cmd_in.step_count     = cmd.step_count;
	assign cmd_in.origin_switch  = cmd.origin_switch;

	sdp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.cmd    (cmd_in),
		.cfg    (cfg),
		.res_d  (res_d)
	);

	sdp_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (acc),
		.push_data  (res_d),
		.push_ready (cmd.ready),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.out_data   (res_out)
	);

	assign res.step_pulse     = res_out.step_pulse;
	assign res.direction_line = res_out.direction_line;
	assign res.driver_enable  = res_out.driver_enable;
	assign res.position       = res_out.position;
	assign res.busy_res       = res_out.busy_res;

	// Skid entry in use implies the main entry holds a result
	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> res.valid)
		else $error("output buffer skid full while main entry empty");

	// Step line only high while a command runs
	a_step_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.step_pulse) |-> res.busy_res)
		else $error("step pulse high while idle");

	// Driver stays enabled through any busy period
	a_busy_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.busy_res) |-> res.driver_enable)
		else $error("busy with driver disabled");

	// A stalled result holds its position
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.position)))
		else $error("stalled result changed");

endmodule

// File: hdl/sdp_cfg.sv
module sdp_cfg
	import sdp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Register file, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= HALF_PERIOD_RST;
			cfg_q.wake_time   <= WAKE_TIME_RST;
			cfg_q.stab_time   <= STAB_TIME_RST;
			cfg_q.origin_dir  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HALF_PERIOD: cfg_q.half_period <= cfg_data;
				REG_WAKE_TIME:   cfg_q.wake_time   <= cfg_data;
				REG_STAB_TIME:   cfg_q.stab_time   <= cfg_data;
				REG_ORIGIN_DIR:  cfg_q.origin_dir  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/sdp_ctrl.sv
module sdp_ctrl
	import sdp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic acc,
	input  cmd_t cmd,
	input  cfg_t cfg,
	output res_t res_d
);

	mode_t                      mode_q, mode_d;
	logic [TIMER_BITS-1:0]      timer_q, timer_d;
	logic [STEP_COUNT_BITS-1:0] steps_q, steps_d;
	logic                       dir_q, dir_d;
	logic                       en_q, en_d;
	logic [POS_W-1:0]           pos_q, pos_d;

	logic                       is_tick;
	logic                       phase_end;
	logic [TIMER_BITS-1:0]      t_dec;
	logic [TIMER_BITS-1:0]      half;
	logic [TIMER_BITS-1:0]      wake_sat;
	logic [TIMER_BITS-1:0]      stab_sat;
	logic [STEP_COUNT_BITS-1:0] cnt;
	logic [STEP_COUNT_BITS-1:0] steps_dec;
	logic                       pos_dir;

	// Shared terms
	assign is_tick   = (cmd.func == FUNC_TICK);
	assign t_dec     = (timer_q != '0) ? timer_q - TIMER_BITS'(1) : '0;
	assign phase_end = is_tick && (mode_q != MODE_IDLE) && (t_dec == '0);
	assign half      = half_ticks(cfg.half_period);
	assign wake_sat  = sat_timer(cfg.wake_time);
	assign stab_sat  = sat_timer(cfg.stab_time);
	assign cnt       = STEP_COUNT_BITS'(cmd.step_count);
	assign steps_dec = steps_q - STEP_COUNT_BITS'(1);
	assign pos_dir   = (dir_q == ~cfg.origin_dir);

	// Next mode
	always_comb begin
		mode_d = mode_q;
		if (acc) begin
			if (is_tick) begin
				if (phase_end) begin
					case (mode_q)
						MODE_MOVE_WAKE: mode_d = (steps_q == '0) ? MODE_IDLE : MODE_MOVE_HIGH;
						MODE_MOVE_HIGH: mode_d = MODE_MOVE_LOW;
						MODE_HOME_HIGH: mode_d = MODE_HOME_LOW;
						MODE_MOVE_LOW:  mode_d = (steps_dec == '0) ? MODE_IDLE : MODE_MOVE_HIGH;
						MODE_HOME_WAKE,
						MODE_HOME_LOW:  mode_d = cmd.origin_switch ? MODE_HOME_HIGH : MODE_IDLE;
						default:        mode_d = MODE_IDLE;
					endcase
				end
			end else if (mode_q == MODE_IDLE) begin
				case (cmd.func)
					FUNC_MOVE: begin
						if (wake_sat != '0)
							mode_d = MODE_MOVE_WAKE;
						else
							mode_d = (cnt == '0) ? MODE_IDLE : MODE_MOVE_HIGH;
					end
					FUNC_HOME: begin
						if (wake_sat != '0)
							mode_d = MODE_HOME_WAKE;
						else
							mode_d = cmd.origin_switch ? MODE_HOME_HIGH : MODE_IDLE;
					end
					FUNC_HOLD: mode_d = (stab_sat == '0) ? MODE_IDLE : MODE_STABILIZE;
					default: ;
				endcase
			end
		end
	end

	// Timer, step counter, line levels and position
	always_comb begin
		timer_d = timer_q;
		steps_d = steps_q;
		dir_d   = dir_q;
		en_d    = en_q;
		pos_d   = pos_q;
		if (acc) begin
			if (is_tick) begin
				if (mode_q != MODE_IDLE && !phase_end) begin
					timer_d = t_dec;
				end else if (phase_end) begin
					case (mode_q)
						MODE_MOVE_WAKE: timer_d = (steps_q == '0) ? '0 : half;
						MODE_MOVE_HIGH,
						MODE_HOME_HIGH: timer_d = half;
						MODE_MOVE_LOW: begin
							pos_d   = pos_dir ? pos_q + POS_W'(1) : pos_q - POS_W'(1);
							steps_d = steps_dec;
							timer_d = (steps_dec == '0) ? '0 : half;
						end
						MODE_HOME_WAKE: begin
							timer_d = cmd.origin_switch ? half : '0;
							if (!cmd.origin_switch)
								pos_d = '0;
						end
						MODE_HOME_LOW: begin
							timer_d = cmd.origin_switch ? half : '0;
							pos_d   = '0;
						end
						default: timer_d = '0;
					endcase
				end
			end else if (mode_q == MODE_IDLE) begin
				case (cmd.func)
					FUNC_MOVE: begin
						dir_d   = cmd.move_direction;
						en_d    = 1'b1;
						steps_d = cnt;
						if (wake_sat != '0)
							timer_d = wake_sat;
						else
							timer_d = (cnt == '0) ? '0 : half;
					end
					FUNC_HOME: begin
						dir_d = cfg.origin_dir;
						en_d  = 1'b1;
						if (wake_sat != '0) begin
							timer_d = wake_sat;
						end else begin
							timer_d = cmd.origin_switch ? half : '0;
							if (!cmd.origin_switch)
								pos_d = '0;
						end
					end
					FUNC_OFF: en_d = 1'b0;
					FUNC_HOLD: begin
						en_d    = 1'b1;
						timer_d = stab_sat;
					end
					default: ;
				endcase
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			timer_q <= '0;
			steps_q <= '0;
			dir_q   <= 1'b0;
			en_q    <= 1'b0;
			pos_q   <= '0;
		end else begin
			mode_q  <= mode_d;
			timer_q <= timer_d;
			steps_q <= steps_d;
			dir_q   <= dir_d;
			en_q    <= en_d;
			pos_q   <= pos_d;
		end
	end

	// Result after the update; step line is high exactly in the high phases
	always_comb begin
		res_d.step_pulse     = (mode_d == MODE_MOVE_HIGH) || (mode_d == MODE_HOME_HIGH);
		res_d.direction_line = dir_d;
		res_d.driver_enable  = en_d;
		res_d.position       = pos_d;
		res_d.busy_res       = (mode_d != MODE_IDLE);
	end

endmodule

// File: hdl/sdp_obuf.sv
module sdp_obuf
	import sdp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic push_ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	logic main_v_q, skid_v_q;
	res_t main_q, skid_q;
	logic slot_free;

	assign slot_free  = !main_v_q || out_ready;
	assign push_ready = !skid_v_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (slot_free) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (slot_free) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = main_v_q;
	assign out_data  = main_q;

endmodule

// File: sim/stepper_step_dir_pulse_controller_core_chk.sv
// Watches both channels and the register port, keeps its own copy of the
// controller and compares every result line with the predicted one.
module stepper_step_dir_pulse_controller_core_chk
	import sdp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sdp_cmd_if                   cmd,
	sdp_res_if                   res,
	input  logic                 done,
	output int                   fault_count
);

	// Register copy
	logic [CFG_W-1:0] half_period;
	logic [CFG_W-1:0] wake_time;
	logic [CFG_W-1:0] stab_time;
	logic             origin_dir;

	// Controller state copy
	mode_t                      mode;
	logic [TIMER_BITS-1:0]      timer;
	logic [STEP_COUNT_BITS-1:0] steps_left;
	logic                       step_lvl;
	logic                       dir_lvl;
	logic                       en_lvl;
	logic [POS_W-1:0]           pos;

	// Output lines owed by the block, oldest first
	res_t due_lines[$];
	logic closed;
	int   line_no;

	initial fault_count = 0;

	task automatic report(input string msg);
		fault_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Half period in ticks; a zero register still gives one tick
	function automatic logic [TIMER_BITS-1:0] pulse_ticks();
		return (half_period == '0) ? TIMER_BITS'(1) : TIMER_BITS'(half_period);
	endfunction

	// Start the next step of a move or go idle when none is left
	task automatic next_step();
		if (steps_left == '0) begin
			mode  = MODE_IDLE;
			timer = '0;
		end else begin
			step_lvl = 1'b1;
			timer    = pulse_ticks();
			mode     = MODE_MOVE_HIGH;
		end
	endtask

	// Homing goes on while the switch reads 1, else stops at position 0
	task automatic next_home(input logic sw);
		if (sw) begin
			step_lvl = 1'b1;
			timer    = pulse_ticks();
			mode     = MODE_HOME_HIGH;
		end else begin
			pos   = '0;
			mode  = MODE_IDLE;
			timer = '0;
		end
	endtask

	// One request into the controller copy
	task automatic advance_controller(input cmd_t r);
		if (r.func == FUNC_TICK) begin
			if (mode != MODE_IDLE) begin
				if (timer != '0)
					timer = timer - TIMER_BITS'(1);
				if (timer == '0) begin
					case (mode)
						MODE_MOVE_WAKE: next_step();
						MODE_MOVE_HIGH, MODE_HOME_HIGH: begin
							step_lvl = 1'b0;
							timer    = pulse_ticks();
							if (mode == MODE_MOVE_HIGH)
								mode = MODE_MOVE_LOW;
							else
								mode = MODE_HOME_LOW;
						end
						MODE_MOVE_LOW: begin
							// sign follows the origin register at step completion
							if (dir_lvl == !origin_dir)
								pos = pos + POS_W'(1);
							else
								pos = pos - POS_W'(1);
							steps_left = steps_left - STEP_COUNT_BITS'(1);
							next_step();
						end
						MODE_HOME_WAKE: next_home(r.origin_switch);
						MODE_HOME_LOW: begin
							pos = '0;
							next_home(r.origin_switch);
						end
						default: begin
							mode  = MODE_IDLE;
							timer = '0;
						end
					endcase
				end
			end
		end else if (mode == MODE_IDLE) begin
			// commands count only while idle
			case (r.func)
				FUNC_MOVE: begin
					dir_lvl    = r.move_direction;
					en_lvl     = 1'b1;
					steps_left = r.step_count;
					timer      = TIMER_BITS'(wake_time);
					mode       = MODE_MOVE_WAKE;
					if (timer == '0)
						next_step();
				end
				FUNC_HOME: begin
					dir_lvl = origin_dir;
					en_lvl  = 1'b1;
					timer   = TIMER_BITS'(wake_time);
					mode    = MODE_HOME_WAKE;
					if (timer == '0)
						next_home(r.origin_switch);
				end
				FUNC_OFF: en_lvl = 1'b0;
				FUNC_HOLD: begin
					en_lvl = 1'b1;
					timer  = TIMER_BITS'(stab_time);
					if (timer == '0)
						mode = MODE_IDLE;
					else
						mode = MODE_STABILIZE;
				end
				default: ;
			endcase
		end
	endtask

	task automatic check_line(input res_t want);
		if (res.step_pulse !== want.step_pulse)
			report($sformatf("line %0d step_pulse %b, want %b", line_no,
				res.step_pulse, want.step_pulse));
		if (res.direction_line !== want.direction_line)
			report($sformatf("line %0d direction_line %b, want %b", line_no,
				res.direction_line, want.direction_line));
		if (res.driver_enable !== want.driver_enable)
			report($sformatf("line %0d driver_enable %b, want %b", line_no,
				res.driver_enable, want.driver_enable));
		if (res.position !== want.position)
			report($sformatf("line %0d position %0d, want %0d", line_no,
				res.position, $signed(want.position)));
		if (res.busy_res !== want.busy_res)
			report($sformatf("line %0d busy_res %b, want %b", line_no,
				res.busy_res, want.busy_res));
	endtask

	always @(posedge clk or negedge arst_n) begin
		cmd_t r;
		res_t want;
		if (!arst_n) begin
			half_period = HALF_PERIOD_RST;
			wake_time   = WAKE_TIME_RST;
			stab_time   = STAB_TIME_RST;
			origin_dir  = 1'b0;
			mode        = MODE_IDLE;
			timer       = '0;
			steps_left  = '0;
			step_lvl    = 1'b0;
			dir_lvl     = 1'b0;
			en_lvl      = 1'b0;
			pos         = '0;
			closed      = 1'b0;
			line_no     = 0;
			due_lines.delete();
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_HALF_PERIOD: half_period = cfg_data;
					REG_WAKE_TIME:   wake_time   = cfg_data;
					REG_STAB_TIME:   stab_time   = cfg_data;
					REG_ORIGIN_DIR:  origin_dir  = cfg_data[0];
					default: ;
				endcase
			end

			// results first: a result never leaves on its own request's edge
			if (res.valid && res.ready) begin
				if (due_lines.size() == 0) begin
					report($sformatf("line %0d arrived with nothing expected", line_no));
				end else begin
					want = due_lines.pop_front();
					check_line(want);
				end
				line_no++;
			end

			// requests
			if (cmd.valid && cmd.ready) begin
				r.func           = cmd.func;
				r.move_direction = cmd.move_direction;
				r.step_count     = cmd.step_count;
				r.origin_switch  = cmd.origin_switch;
				advance_controller(r);
				want.step_pulse     = step_lvl;
				want.direction_line = dir_lvl;
				want.driver_enable  = en_lvl;
				want.position       = pos;
				want.busy_res       = (mode != MODE_IDLE);
				due_lines.push_back(want);
			end

			// end of test: nothing may still be owed
			if (done && !closed) begin
				closed = 1'b1;
				if (due_lines.size() != 0)
					report($sformatf("%0d result lines never arrived", due_lines.size()));
			end
		end
	end

endmodule

// File: sim/stepper_step_dir_pulse_controller_core_tb.sv
// Stimulus for the step/dir controller; checking lives in the checker.
module stepper_step_dir_pulse_controller_core_tb;
	import sdp_pkg::*;

	localparam int         ITEMS       = 2000;
	localparam int         CYCLE_LIMIT = 500000;
	localparam logic [2:0] FUNC_TOP    = 3'd7;  // highest func code

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 done;
	int                   fault_count;

	// Bookkeeping
	int sent     = 0;
	int got      = 0;
	int counted  = 0;
	int cycles   = 0;
	int cfg_sets = 0;
	int moves    = 0;
	int homings  = 0;
	int holds    = 0;
	bit pace_tx  = 1'b1;
	bit pace_rx  = 1'b1;

	// Register values in force, for sequence lengths
	int cur_half;
	int cur_wake;
	int cur_stab;

	sdp_cmd_if cmd ();
	sdp_res_if res ();

	stepper_step_dir_pulse_controller_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.res       (res)
	);

	stepper_step_dir_pulse_controller_core_chk chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.res         (res),
		.done        (done),
		.fault_count (fault_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stalls, with stretches of none
	initial begin
		int stall;
		res.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(39) == 0)
				pace_rx = !pace_rx;
			stall = pace_rx ? $urandom_range(10) : 0;
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			got++;
		end
	end

	// One request; valid stays high into the next one when no gap is drawn
	task automatic send_req(input logic [2:0] f, input logic d, input logic [15:0] n,
		input logic s);
		int gap;
		gap = pace_tx ? $urandom_range(10) : 0;
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid          <= 1'b1;
		cmd.func           <= f;
		cmd.move_direction <= d;
		cmd.step_count     <= n;
		cmd.origin_switch  <= s;
		do @(posedge clk); while (!cmd.ready);
		sent++;
	endtask

	// Hold off until every result is back
	task automatic drain();
		cmd.valid <= 1'b0;
		while (got < sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers back to back; block must be idle
	task automatic set_config(input int h, input int w, input int s, input int o);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HALF_PERIOD;
		cfg_data  <= CFG_W'(h);
		@(posedge clk);
		cfg_index <= REG_WAKE_TIME;
		cfg_data  <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= REG_STAB_TIME;
		cfg_data  <= CFG_W'(s);
		@(posedge clk);
		cfg_index <= REG_ORIGIN_DIR;
		cfg_data  <= CFG_W'(o);
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_half = h;
		cur_wake = w;
		cur_stab = s;
		cfg_sets++;
	endtask

	// A command followed by exactly the ticks that finish it. Homing steps k
	// times; when ragged, the switch may drop early at any sample point.
	task automatic run_cmd(input logic [2:0] f, input logic d, input logic [15:0] n,
		input int k, input bit ragged);
		int   h;
		int   dur;
		int   rel;
		logic sw;
		h = (cur_half == 0) ? 1 : cur_half;
		case (f)
			FUNC_MOVE: dur = cur_wake + 2 * h * int'(n);
			FUNC_HOME: dur = cur_wake + 2 * h * k;
			FUNC_HOLD: dur = cur_stab;
			default:   dur = 0;
		endcase
		if (f == FUNC_HOME && cur_wake == 0)
			sw = (k > 0) && (!ragged || $urandom_range(3) != 0);
		else
			sw = 1'($urandom);
		send_req(f, d, n, sw);
		counted++;
		if (f == FUNC_HOME && cur_wake == 0 && !sw)
			dur = 0;
		for (int t = 1; t <= dur; t++) begin
			// stray command while busy, must be ignored
			if (!ragged && $urandom_range(19) == 0)
				send_req(3'($urandom_range(FUNC_TOP, FUNC_MOVE)), 1'($urandom),
					16'($urandom), 1'($urandom));
			rel = t - cur_wake;
			if (f == FUNC_HOME && rel >= 0 && rel % (2 * h) == 0)
				sw = (rel / (2 * h) < k) && (!ragged || $urandom_range(3) != 0);
			else
				sw = 1'($urandom);
			send_req(FUNC_TICK, 1'($urandom), 16'($urandom), sw);
			counted++;
		end
	endtask

	initial begin
		int          phase_end;
		int          pick;
		int          r;
		logic [15:0] n;

		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_HALF_PERIOD;
		cfg_data           <= '0;
		done               <= 1'b0;
		cmd.valid          <= 1'b0;
		cmd.func           <= FUNC_TICK;
		cmd.move_direction <= 1'b0;
		cmd.step_count     <= '0;
		cmd.origin_switch  <= 1'b0;
		cur_half = 1000;
		cur_wake = 100000;
		cur_stab = 200000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: only requests that leave the block idle
		send_req(FUNC_TICK, 1'b1, 16'hFFFF, 1'b1);
		send_req(FUNC_OFF, 1'b0, 16'h0000, 1'b0);
		send_req(FUNC_TOP, 1'b1, 16'hFFFF, 1'b1);
		drain();

		// Fastest timing: no wake, no stabilize, one-tick half period
		set_config(1, 0, 0, 0);
		run_cmd(FUNC_MOVE, 1'b1, 16'd0, 0, 1'b0);
		run_cmd(FUNC_MOVE, 1'b0, 16'd2, 0, 1'b0);
		// a one-step move; the move and off commands sent during it are dropped
		send_req(FUNC_MOVE, 1'b1, 16'd1, 1'b0);
		send_req(FUNC_MOVE, 1'b0, 16'hFFFF, 1'b1);
		send_req(FUNC_OFF, 1'b1, 16'h0000, 1'b0);
		send_req(FUNC_TICK, 1'b0, 16'h0000, 1'b0);
		send_req(FUNC_TICK, 1'b1, 16'hFFFF, 1'b1);
		run_cmd(FUNC_HOLD, 1'b0, 16'd0, 0, 1'b0);
		run_cmd(FUNC_OFF, 1'b0, 16'd0, 0, 1'b0);
		run_cmd(FUNC_HOME, 1'b0, 16'd0, 0, 1'b0);
		run_cmd(FUNC_HOME, 1'b1, 16'd0, 2, 1'b0);
		send_req(3'(FUNC_HOLD + 1), 1'b1, 16'h5555, 1'b1);
		drain();

		// Zero half period acts as one; origin on the high level
		set_config(0, 2, 3, 1);
		run_cmd(FUNC_MOVE, 1'b1, 16'd2, 0, 1'b0);
		run_cmd(FUNC_MOVE, 1'b0, 16'd1, 0, 1'b0);
		run_cmd(FUNC_HOME, 1'b0, 16'd0, 1, 1'b0);
		run_cmd(FUNC_HOLD, 1'b0, 16'd0, 0, 1'b0);
		drain();

		// Full-scale timing, exercised only with idle-safe requests
		set_config(1000000, 1000000, 1000000, 1);
		send_req(FUNC_TICK, 1'b1, 16'hAAAA, 1'b0);
		send_req(FUNC_OFF, 1'b0, 16'h0000, 1'b1);
		send_req(FUNC_TOP, 1'b0, 16'h0000, 1'b0);
		send_req(FUNC_TICK, 1'b0, 16'h5555, 1'b1);
		drain();

		// Random phases, each with its own timing
		while (counted < ITEMS) begin
			drain();
			set_config(($urandom_range(4) == 0) ? $urandom_range(8) : $urandom_range(2),
				($urandom_range(3) == 0) ? 0 : $urandom_range(8),
				$urandom_range(6), $urandom_range(1));
			phase_end = counted + 250;
			while (counted < phase_end) begin
				if ($urandom_range(7) == 0)
					pace_tx = !pace_tx;
				pick = $urandom_range(99);
				if (pick < 40) begin
					r = $urandom_range(99);
					if (r < 70 || cur_half > 2)
						n = 16'($urandom_range(4));
					else if (r < 98)
						n = 16'($urandom_range(20, 5));
					else
						n = 16'($urandom_range(200, 60));
					moves++;
					run_cmd(FUNC_MOVE, 1'($urandom), n, 0, 1'b0);
				end else if (pick < 65) begin
					homings++;
					run_cmd(FUNC_HOME, 1'($urandom), 16'($urandom), $urandom_range(4),
						$urandom_range(4) == 0);
				end else if (pick < 75) begin
					holds++;
					run_cmd(FUNC_HOLD, 1'($urandom), 16'($urandom), 0, 1'b0);
				end else if (pick < 85) begin
					run_cmd(FUNC_OFF, 1'($urandom), 16'($urandom), 0, 1'b0);
				end else if (pick < 93) begin
					// idle tick
					send_req(FUNC_TICK, 1'($urandom), 16'($urandom), 1'($urandom));
				end else begin
					// unknown code
					send_req(3'($urandom_range(FUNC_TOP, FUNC_HOLD + 1)), 1'($urandom),
						16'($urandom), 1'($urandom));
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		done <= 1'b1;
		repeat (3) @(posedge clk);

		$display("%0d requests, %0d results; %0d moves, %0d homings, %0d holds",
			sent, got, moves, homings, holds);
		$display("%0d register settings incl. zero and full-scale timing, %0d cycles",
			cfg_sets, cycles);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
